/* rtl/core/u8s_pkg.sv */
package u8s_pkg;

  // Default depth of the queue between the classifier and the byte emitter
  localparam int unsigned QueueDepthDefault = 4;

  // Byte boundaries of UTF-8 lead and continuation classes
  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] LeadMin    = 8'hC2;
  localparam logic [7:0] LeadMax    = 8'hF4;
  localparam logic [7:0] Lead3Min   = 8'hE0;
  localparam logic [7:0] Lead4Min   = 8'hF0;
  localparam logic [7:0] LeadE0     = 8'hE0;
  localparam logic [7:0] LeadED     = 8'hED;
  localparam logic [7:0] LeadF0     = 8'hF0;
  localparam logic [7:0] LeadF4     = 8'hF4;
  localparam logic [7:0] ContLo     = 8'h80;
  localparam logic [7:0] ContHi     = 8'hBF;
  localparam logic [7:0] ContLoE0   = 8'hA0;
  localparam logic [7:0] ContHiED   = 8'h9F;
  localparam logic [7:0] ContLoF0   = 8'h90;
  localparam logic [7:0] ContHiF4   = 8'h8F;

  // Sequence lengths
  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  // U+FFFD encoding
  localparam logic [7:0] ReplByte0 = 8'hEF;
  localparam logic [7:0] ReplByte1 = 8'hBF;
  localparam logic [7:0] ReplByte2 = 8'hBD;
  localparam logic [2:0] ReplLen   = 3'd3;

  // Class of a byte seen in lead position
  typedef enum logic [1:0] {
    LeadAscii = 2'd0,
    LeadBad   = 2'd1,
    LeadStart = 2'd2
  } lead_kind_e;

  // Work for one accepted byte: [FFFD if pre] [lit bytes] [FFFD if post]
  typedef struct packed {
    logic            pre;
    logic            post;
    logic [2:0]      lit_cnt;
    logic [3:0][7:0] lits;
    logic            eot;
  } desc_t;

  // Queue status seen by the classifier and the emitter
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Byte of the replacement character at position idx
  function automatic logic [7:0] repl_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = ReplByte0;
      2'd1:    r = ReplByte1;
      default: r = ReplByte2;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/utf8_sanitizer_maximal_subpart.sv */
// UTF-8 sanitizer with maximal-subpart replacement.
// Input channel: in_valid_i / in_stall_o carry one raw byte (in_byte_i) and
// an end-of-text flag per transaction. Output channel: out_valid_o /
// out_stall_i carry one sanitized byte per transaction, with flags marking
// replacement bytes (EF BF BD), the last byte caused by an input byte, and
// the last byte of the text.
// An input byte causes 0 to 6 output bytes. A byte that only extends an
// unfinished sequence causes none; a completed sequence is sent in full when
// its last byte arrives.
// With an idle queue and emitter, the first output byte of a transaction
// passes through the queue write and then the output register. One input
// byte per cycle is taken while the queue is not full, and one output byte
// per cycle is sent while the receiver does not stall; the emitter sends the
// bytes of a queued transaction in turn and pops it after the last one.
// A queue of QueueDepth transactions between classifier and emitter absorbs
// bursts. in_stall_o is high only while that queue is full.
// When the receiver stalls, the output register holds its byte and the queue
// fills, then the input stalls. Reset clears the held prefix, the queue and
// the output valid; nothing else needs clearing.
module utf8_sanitizer_maximal_subpart #(
  parameter int unsigned QueueDepth = u8s_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       is_replacement_o,
  output logic       last_of_run_o,
  output logic       text_done_o
);

  logic                accept;
  logic                push;
  logic                pop;
  u8s_pkg::desc_t      push_desc;
  u8s_pkg::desc_t      head_desc;
  u8s_pkg::q_status_t  q_status;

  assign in_stall_o = q_status.full;
  assign accept     = in_valid_i && !in_stall_o;

  // Classifier and hold state
  u8s_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push),
    .desc_o        (push_desc)
  );

  // Work queue
  u8s_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_desc),
    .pop_i    (pop),
    .data_o   (head_desc),
    .status_o (q_status)
  );

  // Byte emitter
  u8s_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_desc),
    .head_valid_i     (!q_status.empty),
    .pop_o            (pop),
    .out_byte_o       (out_byte_o),
    .is_replacement_o (is_replacement_o),
    .last_of_run_o    (last_of_run_o),
    .text_done_o      (text_done_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i)
  );

`ifndef ASSERT_OFF
  // Queue never takes a transaction while full
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_status.full))
    else $error("push into full queue");

  // Idle with nothing queued stays idle without a push
  a_idle_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_status.empty && !out_valid_o && !push) |=> !out_valid_o)
    else $error("output appeared from empty queue");

  // Work pushed into an idle emitter is offered once it has left the queue
  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && q_status.empty && !out_valid_o) |=> ##1 out_valid_o)
    else $error("queued work not emitted");
`endif

endmodule

/* rtl/core/u8s_front.sv */
module u8s_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic               end_of_text_i,
  output logic               push_o,
  output u8s_pkg::desc_t     desc_o
);

  logic [2:0][7:0] held_bytes_q;
  logic [1:0]      held_count_q, held_count_d;
  logic [2:0]      seq_len_q, seq_len_d;

  logic                 holding;
  logic [7:0]           lo, hi;
  logic                 cont_ok;
  u8s_pkg::lead_kind_e  kind;
  logic [2:0]           lead_len;
  logic                 do_lead;
  logic [2:0]           held_used;
  logic                 hb_we;
  logic [1:0]           hb_idx;
  u8s_pkg::desc_t       desc;

  // Classify the byte as a lead
  always_comb begin
    lead_len = u8s_pkg::SeqLen2;
    if (in_byte_i < u8s_pkg::AsciiLimit) begin
      kind = u8s_pkg::LeadAscii;
    end else if (in_byte_i < u8s_pkg::LeadMin || in_byte_i > u8s_pkg::LeadMax) begin
      kind = u8s_pkg::LeadBad;
    end else begin
      kind = u8s_pkg::LeadStart;
      if (in_byte_i < u8s_pkg::Lead3Min) begin
        lead_len = u8s_pkg::SeqLen2;
      end else if (in_byte_i < u8s_pkg::Lead4Min) begin
        lead_len = u8s_pkg::SeqLen3;
      end else begin
        lead_len = u8s_pkg::SeqLen4;
      end
    end
  end

  // Continuation range; narrowed only right after certain leads
  always_comb begin
    lo = u8s_pkg::ContLo;
    hi = u8s_pkg::ContHi;
    if (held_count_q == 2'd1) begin
      case (held_bytes_q[0])
        u8s_pkg::LeadE0: lo = u8s_pkg::ContLoE0;
        u8s_pkg::LeadED: hi = u8s_pkg::ContHiED;
        u8s_pkg::LeadF0: lo = u8s_pkg::ContLoF0;
        u8s_pkg::LeadF4: hi = u8s_pkg::ContHiF4;
        default: ;
      endcase
    end
    cont_ok = (in_byte_i >= lo) && (in_byte_i <= hi);
  end

  // Next hold state and the work descriptor
  always_comb begin
    holding      = (held_count_q != 2'd0) && (seq_len_q >= u8s_pkg::SeqLen2);
    held_count_d = held_count_q;
    seq_len_d    = seq_len_q;
    do_lead      = 1'b0;
    held_used    = 3'd0;
    hb_we        = 1'b0;
    hb_idx       = held_count_q;
    desc         = '0;
    desc.eot     = end_of_text_i;

    if (!holding) begin
      do_lead      = 1'b1;
      held_count_d = 2'd0;
      seq_len_d    = 3'd0;
    end else if (cont_ok) begin
      if ({1'b0, held_count_q} + 3'd1 >= seq_len_q) begin
        // sequence complete: flush held bytes and this one
        held_used    = {1'b0, held_count_q};
        desc.lit_cnt = {1'b0, held_count_q} + 3'd1;
        held_count_d = 2'd0;
        seq_len_d    = 3'd0;
      end else begin
        hb_we        = 1'b1;
        hb_idx       = held_count_q;
        held_count_d = held_count_q + 2'd1;
      end
    end else begin
      // held maximal subpart replaced, byte taken again as a lead
      desc.pre     = 1'b1;
      do_lead      = 1'b1;
      held_count_d = 2'd0;
      seq_len_d    = 3'd0;
    end

    if (do_lead) begin
      case (kind)
        u8s_pkg::LeadAscii: desc.lit_cnt = 3'd1;
        u8s_pkg::LeadBad:   desc.post    = 1'b1;
        u8s_pkg::LeadStart: begin
          hb_we        = 1'b1;
          hb_idx       = 2'd0;
          held_count_d = 2'd1;
          seq_len_d    = lead_len;
        end
        default: ;
      endcase
    end

    // end of text drops any open prefix
    if (end_of_text_i) begin
      if (held_count_d != 2'd0) begin
        desc.post = 1'b1;
      end
      held_count_d = 2'd0;
      seq_len_d    = 3'd0;
    end

    // held bytes first, then this byte; the last slot is only ever this byte
    for (int i = 0; i < 3; i++) begin
      desc.lits[i] = (3'(i) < held_used) ? held_bytes_q[i[1:0]] : in_byte_i;
    end
    desc.lits[3] = in_byte_i;
  end

  assign desc_o = desc;
  assign push_o = accept_i && (desc.pre || desc.post || (desc.lit_cnt != 3'd0));

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= 2'd0;
      seq_len_q    <= 3'd0;
    end else if (accept_i) begin
      held_count_q <= held_count_d;
      seq_len_q    <= seq_len_d;
    end
  end

  // Held bytes, no reset
  always_ff @(posedge clk_i) begin
    if (accept_i && hb_we) begin
      held_bytes_q[hb_idx] <= in_byte_i;
    end
  end

endmodule

/* rtl/core/u8s_fifo.sv */
module u8s_fifo #(
  parameter int unsigned Depth = u8s_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  u8s_pkg::desc_t      data_i,
  input  logic                pop_i,
  output u8s_pkg::desc_t      data_o,
  output u8s_pkg::q_status_t  status_o
);

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  u8s_pkg::desc_t      mem_q [Depth];
  logic [AddrW-1:0]    wptr_q, rptr_q;
  logic [CountW-1:0]   count_q;
  logic                do_push, do_pop;

  assign status_o.full  = (count_q == CountW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign data_o         = mem_q[rptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AddrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AddrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

/* rtl/core/u8s_back.sv */
module u8s_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  u8s_pkg::desc_t      head_i,
  input  logic                head_valid_i,
  output logic                pop_o,
  output logic [7:0]          out_byte_o,
  output logic                is_replacement_o,
  output logic                last_of_run_o,
  output logic                text_done_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);

  logic [2:0] pos_q, pos_d;
  logic       valid_q;
  logic [7:0] byte_q, byte_d;
  logic       repl_q, repl_d;
  logic       last_q;
  logic       done_q;

  logic [2:0] pre_len, post_len, total, rel, tail;
  logic       last;
  logic       advance;

  // Pick byte at the current position of the head descriptor
  always_comb begin
    pre_len  = head_i.pre  ? u8s_pkg::ReplLen : 3'd0;
    post_len = head_i.post ? u8s_pkg::ReplLen : 3'd0;
    total    = pre_len + head_i.lit_cnt + post_len;
    rel      = pos_q - pre_len;
    tail     = rel - head_i.lit_cnt;
    last     = (pos_q == total - 3'd1);
    if (pos_q < pre_len) begin
      byte_d = u8s_pkg::repl_byte(pos_q[1:0]);
      repl_d = 1'b1;
    end else if (rel < head_i.lit_cnt) begin
      byte_d = head_i.lits[rel[1:0]];
      repl_d = 1'b0;
    end else begin
      byte_d = u8s_pkg::repl_byte(tail[1:0]);
      repl_d = 1'b1;
    end
  end

  assign advance = !valid_q || !out_stall_i;
  assign pop_o   = advance && head_valid_i && last;
  assign pos_d   = last ? 3'd0 : pos_q + 3'd1;

  // Position within the head descriptor and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 3'd0;
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= head_valid_i;
      if (head_valid_i) begin
        pos_q <= pos_d;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (advance && head_valid_i) begin
      byte_q <= byte_d;
      repl_q <= repl_d;
      last_q <= last;
      done_q <= last && head_i.eot;
    end
  end

  assign out_valid_o      = valid_q;
  assign out_byte_o       = byte_q;
  assign is_replacement_o = repl_q;
  assign last_of_run_o    = last_q;
  assign text_done_o      = done_q;

endmodule

/* tb/sv/utf8_sanitizer_maximal_subpart_tb.sv */
module utf8_sanitizer_maximal_subpart_tb;

  // One raw input byte and one sanitized output byte
  typedef struct {
    logic [7:0] data;
    logic       eot;
  } text_byte_t;

  typedef struct {
    logic [7:0] data;
    logic       repl;
    logic       last;
    logic       done;
  } clean_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       end_of_text_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic       is_replacement_o;
  logic       last_of_run_o;
  logic       text_done_o;

  utf8_sanitizer_maximal_subpart dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .end_of_text_i   (end_of_text_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .is_replacement_o(is_replacement_o),
    .last_of_run_o   (last_of_run_o),
    .text_done_o     (text_done_o)
  );

  always #5 clk_i = ~clk_i;

  // Directed text: bit 8 marks end of text
  logic [8:0] directed_text [29] = '{
    9'h000, 9'h17F, 9'h080, 9'h0C1, 9'h0F5, 9'h0FF,   // ASCII bounds, bad leads
    9'h0C2, 9'h1BF,                                   // 2-byte, ends text
    9'h0E0, 9'h0A0, 9'h080,                           // E0 lowest second byte
    9'h0E0, 9'h09F,                                   // E0 second byte too low
    9'h0ED, 9'h09F, 9'h0BF,                           // ED highest second byte
    9'h0ED, 9'h0A0,                                   // ED surrogate range
    9'h0F0, 9'h090, 9'h080, 9'h080,                   // F0 lowest 4-byte
    9'h0F4, 9'h08F, 9'h041,                           // truncated by ASCII
    9'h0F4, 9'h090,                                   // above U+10FFFF
    9'h0E1, 9'h180                                    // prefix held at end of text
  };

  text_byte_t  text_q [$];    // raw bytes still to be sent
  clean_byte_t clean_q [$];   // sanitized bytes still to arrive
  clean_byte_t run_q [$];     // bytes caused by the current input byte

  // Sanitizer state mirror
  logic [7:0] held_q [3];
  int         held_n   = 0;
  int         need_len = 0;

  int  n_offered = 0;
  int  n_taken   = 0;
  int  n_total   = 0;
  int  errors    = 0;
  int  idle_left = 0;
  int  stall_left = 0;
  int  cycle_n   = 0;
  bit  hold_off  = 1'b0;
  text_byte_t  item;
  clean_byte_t want;

  function automatic void push_out(logic [7:0] b, logic repl);
    clean_byte_t c;
    c.data = b;
    c.repl = repl;
    c.last = 1'b0;
    c.done = 1'b0;
    run_q.push_back(c);
  endfunction

  function automatic void push_fffd();
    push_out(u8s_pkg::ReplByte0, 1'b1);
    push_out(u8s_pkg::ReplByte1, 1'b1);
    push_out(u8s_pkg::ReplByte2, 1'b1);
  endfunction

  function automatic void clear_hold();
    held_n   = 0;
    need_len = 0;
  endfunction

  function automatic void take_lead(logic [7:0] b);
    if (b < u8s_pkg::AsciiLimit) begin
      push_out(b, 1'b0);
    end else if (b < u8s_pkg::LeadMin || b > u8s_pkg::LeadMax) begin
      push_fffd();
    end else begin
      held_q[0] = b;
      held_n    = 1;
      need_len  = (b < u8s_pkg::Lead3Min) ? 2 : ((b < u8s_pkg::Lead4Min) ? 3 : 4);
    end
  endfunction

  function automatic bit cont_fits(logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = u8s_pkg::ContLo;
    hi = u8s_pkg::ContHi;
    if (held_n == 1) begin
      case (held_q[0])
        u8s_pkg::LeadE0: lo = u8s_pkg::ContLoE0;
        u8s_pkg::LeadED: hi = u8s_pkg::ContHiED;
        u8s_pkg::LeadF0: lo = u8s_pkg::ContLoF0;
        u8s_pkg::LeadF4: hi = u8s_pkg::ContHiF4;
        default: ;
      endcase
    end
    return b >= lo && b <= hi;
  endfunction

  // Expected output bytes for one accepted input byte
  function automatic void sanitize_byte(logic [7:0] b, logic eot);
    run_q.delete();
    if (held_n == 0) begin
      take_lead(b);
    end else if (cont_fits(b)) begin
      if (held_n + 1 >= need_len) begin
        for (int i = 0; i < held_n; i++) push_out(held_q[i], 1'b0);
        push_out(b, 1'b0);
        clear_hold();
      end else begin
        held_q[held_n] = b;
        held_n++;
      end
    end else begin
      // held maximal subpart becomes one FFFD, byte retried as a lead
      push_fffd();
      clear_hold();
      take_lead(b);
    end
    if (eot) begin
      if (held_n != 0) push_fffd();
      clear_hold();
    end
    if (run_q.size() > 0) begin
      run_q[run_q.size()-1].last = 1'b1;
      run_q[run_q.size()-1].done = eot;
    end
    foreach (run_q[i]) clean_q.push_back(run_q[i]);
  endfunction

  function automatic void add_text(logic [7:0] b, logic eot);
    text_byte_t t;
    t.data = b;
    t.eot  = eot;
    text_q.push_back(t);
  endfunction

  // Well-formed character of len bytes with random content
  function automatic void make_char(int len, ref logic [7:0] seq [$]);
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    seq.delete();
    if (len == 1) begin
      seq.push_back(8'($urandom_range(0, 8'h7F)));
      return;
    end
    case (len)
      2:       lead = 8'($urandom_range(u8s_pkg::LeadMin, 8'hDF));
      3:       lead = 8'($urandom_range(u8s_pkg::Lead3Min, 8'hEF));
      default: lead = 8'($urandom_range(u8s_pkg::Lead4Min, u8s_pkg::LeadMax));
    endcase
    lo = u8s_pkg::ContLo;
    hi = u8s_pkg::ContHi;
    case (lead)
      u8s_pkg::LeadE0: lo = u8s_pkg::ContLoE0;
      u8s_pkg::LeadED: hi = u8s_pkg::ContHiED;
      u8s_pkg::LeadF0: lo = u8s_pkg::ContLoF0;
      u8s_pkg::LeadF4: hi = u8s_pkg::ContHiF4;
      default: ;
    endcase
    seq.push_back(lead);
    seq.push_back(8'($urandom_range(lo, hi)));
    for (int i = 2; i < len; i++) begin
      seq.push_back(8'($urandom_range(u8s_pkg::ContLo, u8s_pkg::ContHi)));
    end
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Input side: record accepted transactions
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sanitize_byte(in_byte_i, end_of_text_i);
      n_taken++;
    end
  end

  // Input driver
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && n_taken != n_offered)) begin
      if (idle_left > 0) begin
        in_valid_i <= 1'b0;
        idle_left--;
      end else if (text_q.size() > 0) begin
        item = text_q.pop_front();
        in_byte_i     <= item.data;
        end_of_text_i <= item.eot;
        in_valid_i    <= 1'b1;
        n_offered++;
        // every third block of 32 bytes is sent back to back
        if (hold_off || (n_offered / 32) % 3 == 2) idle_left = 0;
        else idle_left = pick_idle();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      cycle_n++;
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if ((cycle_n / 100) % 3 == 1 || $urandom_range(0, 99) < 60) begin
        out_stall_i <= 1'b0;
      end else begin
        stall_left = pick_idle();
        out_stall_i <= 1'b1;
      end
    end
  end

  // Output checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (clean_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output byte=%h repl=%b last=%b done=%b", $time,
                 out_byte_o, is_replacement_o, last_of_run_o, text_done_o);
      end else begin
        want = clean_q.pop_front();
        if (out_byte_o !== want.data || is_replacement_o !== want.repl ||
            last_of_run_o !== want.last || text_done_o !== want.done) begin
          errors++;
          $display("%0t: expected byte=%h repl=%b last=%b done=%b, got byte=%h repl=%b last=%b done=%b",
                   $time, want.data, want.repl, want.last, want.done,
                   out_byte_o, is_replacement_o, last_of_run_o, text_done_o);
        end
      end
    end
  end

  // Long receiver hold-off so the internal queue fills and input stalls
  initial begin
    wait (rst_ni === 1'b1);
    while (n_taken < 80) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (64) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Stimulus, reset and end of test
  initial begin
    logic [7:0] seq [$];
    int pick;
    int k;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_byte_i     = 8'h00;
    end_of_text_i = 1'b0;
    out_stall_i   = 1'b0;

    foreach (directed_text[i]) add_text(directed_text[i][7:0], directed_text[i][8]);

    // random text: mostly well-formed characters, some truncated or broken
    while (text_q.size() < 210) begin
      pick = $urandom_range(0, 99);
      make_char($urandom_range(1, 4), seq);
      if (pick < 55 || (seq.size() == 1 && pick < 85)) begin
        foreach (seq[i]) add_text(seq[i], 1'b0);
      end else if (pick < 70) begin
        k = $urandom_range(1, seq.size() - 1);
        for (int i = 0; i < k; i++) add_text(seq[i], 1'b0);
      end else if (pick < 85) begin
        k = $urandom_range(1, seq.size() - 1);
        for (int i = 0; i < k; i++) add_text(seq[i], 1'b0);
        if ($urandom_range(0, 1)) add_text(8'($urandom_range(0, 8'h7F)), 1'b0);
        else add_text(8'($urandom_range(8'hC0, 8'hFF)), 1'b0);
      end else begin
        add_text(8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 99) < 8) text_q[text_q.size()-1].eot = 1'b1;
    end
    n_total = text_q.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (n_taken < n_total || clean_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && clean_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/u8s_pkg.sv
rtl/core/u8s_front.sv
rtl/core/u8s_fifo.sv
rtl/core/u8s_back.sv
rtl/core/utf8_sanitizer_maximal_subpart.sv
tb/sv/utf8_sanitizer_maximal_subpart_tb.sv
